FILE: hdl/hst_pkg.sv
// Package: shared types and constants for the hashed symbol table
`default_nettype none
package hst_pkg;
   localparam int TABLE_DEPTH = 256;
   localparam int MAX_KEY_LEN = 8;
   localparam int SIZE_W = 9;
   localparam int HASH_W = 32;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd251;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_MISS    = 2'd1,
      ST_FULL    = 2'd2,
      ST_TOOLONG = 2'd3
   } status_type;

   typedef struct packed {
      logic             insert;
      logic             too_long;
      logic [HASH_W-1:0] hash;
      logic [63:0]      key;
      logic [3:0]       key_len;
      logic [7:0]       code;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MOD,
      BK_READ,
      BK_CHECK,
      BK_DONE
   } back_state_type;

   function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] b);
      logic [HASH_W-1:0] t;
      logic [HASH_W-1:0] g;
      t = (h << 4) + {24'd0, b};
      g = t & 32'hf000_0000;
      if (g != '0) begin
         t = t ^ (g >> 24) ^ g;
      end
      return t;
   endfunction
endpackage
`default_nettype wire

FILE: hdl/hst_front.sv
// Front end: folds key bytes into the hash and assembles the key word
`default_nettype none
module hst_front #(
   parameter int MAX_KEY_LEN = hst_pkg::MAX_KEY_LEN
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire logic            req_req_type,
   input  wire logic [7:0]      req_key_byte,
   input  wire logic [7:0]      req_token_code,
   output logic                 job_valid,
   input  wire logic            job_full,
   output hst_pkg::job_type     job_data
);
   logic                         started_ff, started_in;
   logic                         insert_ff, insert_in;
   logic                         long_ff, long_in;
   logic [hst_pkg::HASH_W-1:0]   hash_ff, hash_in;
   logic [63:0]                  key_ff, key_in;
   logic [3:0]                   len_ff, len_in;
   logic                         acc;
   logic                         ins_now;

   assign req_stall = job_full;
   assign acc = req_valid && !req_stall;
   assign ins_now = started_ff ? insert_ff : req_req_type;

   always_comb begin
      started_in = started_ff;
      insert_in  = insert_ff;
      long_in    = long_ff;
      hash_in    = hash_ff;
      key_in     = key_ff;
      len_in     = len_ff;
      if (acc) begin
         if (req_key_byte == 8'd0) begin
            started_in = 1'b0;
            long_in    = 1'b0;
            hash_in    = '0;
            key_in     = '0;
            len_in     = '0;
         end else begin
            started_in = 1'b1;
            insert_in  = ins_now;
            hash_in    = hst_pkg::fold_byte(hash_ff, req_key_byte);
            if (len_ff < 4'(MAX_KEY_LEN)) begin
               key_in = key_ff | ({56'd0, req_key_byte} << {len_ff[2:0], 3'b000});
               len_in = len_ff + 4'd1;
            end else begin
               long_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         insert_ff  <= 1'b0;
         long_ff    <= 1'b0;
         hash_ff    <= '0;
         key_ff     <= '0;
         len_ff     <= '0;
      end else begin
         started_ff <= started_in;
         insert_ff  <= insert_in;
         long_ff    <= long_in;
         hash_ff    <= hash_in;
         key_ff     <= key_in;
         len_ff     <= len_in;
      end
   end

   assign job_valid        = acc && (req_key_byte == 8'd0);
   assign job_data.insert  = ins_now;
   assign job_data.too_long = long_ff;
   assign job_data.hash    = hash_ff;
   assign job_data.key     = key_ff;
   assign job_data.key_len = len_ff;
   assign job_data.code    = req_token_code;
endmodule
`default_nettype wire

FILE: hdl/hst_queue.sv
// Two-entry queue of finished keys between front and back
`default_nettype none
module hst_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        wr_valid,
   output logic             wr_full,
   input  wire hst_pkg::job_type wr_data,
   output logic             rd_valid,
   input  wire logic        rd_take,
   output hst_pkg::job_type rd_data
);
   hst_pkg::job_type mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign wr_full  = (cnt_ff == 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rp_ff];
   assign push = wr_valid && !wr_full;
   assign pop  = rd_take && rd_valid;

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end
endmodule
`default_nettype wire

FILE: hdl/hst_back.sv
// Back end: modulo reduction, probe walk over the slot memory, result register
`default_nettype none
module hst_back #(
   parameter int TABLE_DEPTH = hst_pkg::TABLE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [8:0]        csr_table_size,
   input  wire logic              job_valid,
   output logic                   job_take,
   input  wire hst_pkg::job_type  job_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_status,
   output logic [7:0]             rsp_slot_index,
   output logic [7:0]             rsp_found_code
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = AW + 1;
   localparam int HW = hst_pkg::HASH_W;

   logic [8:0]  size_ff;
   logic [CW-1:0] m;
   always_comb begin
      if (size_ff < 9'd3) m = CW'(3);
      else if (32'(size_ff) > 32'(TABLE_DEPTH)) m = CW'(TABLE_DEPTH);
      else m = CW'(size_ff);
   end

   // slot stores, valid bits in flops, payload in memory
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [63:0] key_mem  [TABLE_DEPTH];
   logic [3:0]  klen_mem [TABLE_DEPTH];
   logic [7:0]  code_mem [TABLE_DEPTH];
   logic [63:0] rkey_ff;
   logic [3:0]  rlen_ff;
   logic [7:0]  rcode_ff;
   logic        rvalid_ff;

   hst_pkg::back_state_type st_ff, st_in;
   hst_pkg::job_type job_ff;
   logic [HW-1:0]  rem_ff, rem_in;
   logic [5:0]     bit_ff, bit_in;
   logic [AW-1:0]  pos_ff, pos_in, home_ff;
   logic [CW-1:0]  n_ff, n_in;
   logic [CW-1:0]  cnt_ff;
   logic [1:0]     pst_ff;
   logic [7:0]     pslot_ff, pcode_ff;
   logic [1:0]     ost_ff;
   logic [7:0]     oslot_ff, ocode_ff;
   logic           ovalid_ff;

   logic [HW:0]    trial;
   logic [AW-1:0]  pos_next;
   logic           wr_en, res_en;
   logic [1:0]     res_st;
   logic [AW-1:0]  res_slot;
   logic [7:0]     res_code;

   assign csr_ready = 1'b1;
   assign job_take  = (st_ff == hst_pkg::BK_IDLE) && job_valid;
   assign trial = {rem_ff, job_ff.hash[bit_ff[4:0]]} - {{(HW+1-CW){1'b0}}, m};
   assign pos_next = ({1'b0, pos_ff} + CW'(1) == m) ? '0 : pos_ff + AW'(1);

   always_comb begin
      unique case (st_ff)
         hst_pkg::BK_IDLE:  st_in = job_valid ? hst_pkg::BK_MOD : hst_pkg::BK_IDLE;
         hst_pkg::BK_MOD:   st_in = (bit_ff == 6'd0) ?
                               (job_ff.too_long ? hst_pkg::BK_DONE : hst_pkg::BK_READ)
                               : hst_pkg::BK_MOD;
         hst_pkg::BK_READ:  st_in = hst_pkg::BK_CHECK;
         hst_pkg::BK_CHECK: st_in = res_en ? hst_pkg::BK_DONE : hst_pkg::BK_READ;
         hst_pkg::BK_DONE:  st_in = (!ovalid_ff || !rsp_stall) ? hst_pkg::BK_IDLE
                                                              : hst_pkg::BK_DONE;
         default:           st_in = hst_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      rem_in = rem_ff;
      bit_in = bit_ff;
      pos_in = pos_ff;
      n_in   = n_ff;
      wr_en  = 1'b0;
      res_en = 1'b0;
      res_st = hst_pkg::ST_OK;
      res_slot = pos_ff;
      res_code = '0;
      unique case (st_ff)
         hst_pkg::BK_IDLE: begin
            rem_in = '0;
            bit_in = 6'd31;
            n_in   = '0;
         end
         hst_pkg::BK_MOD: begin
            if (!trial[HW]) rem_in = trial[HW-1:0];
            else rem_in = {rem_ff[HW-2:0], job_ff.hash[bit_ff[4:0]]};
            bit_in = bit_ff - 6'd1;
            pos_in = AW'(trial[HW] ? {rem_ff[HW-2:0], job_ff.hash[bit_ff[4:0]]}
                                   : trial[HW-1:0]);
         end
         hst_pkg::BK_CHECK: begin
            if (job_ff.insert) begin
               if (CW'(cnt_ff + CW'(1)) >= (m >> 1) || cnt_ff == {CW{1'b1}}) begin
                  res_en = 1'b1;
                  res_st = hst_pkg::ST_FULL;
                  res_slot = '0;
               end else if (!rvalid_ff) begin
                  res_en = 1'b1;
                  wr_en  = 1'b1;
               end else if (n_ff + CW'(1) == m) begin
                  res_en = 1'b1;
                  res_st = hst_pkg::ST_FULL;
                  res_slot = '0;
               end
            end else begin
               if (!rvalid_ff) begin
                  res_en = 1'b1;
                  res_st = hst_pkg::ST_MISS;
               end else if (rlen_ff == job_ff.key_len && rkey_ff == job_ff.key) begin
                  res_en = 1'b1;
                  res_code = rcode_ff;
               end else if (n_ff + CW'(1) == m) begin
                  res_en = 1'b1;
                  res_st = hst_pkg::ST_MISS;
                  res_slot = home_ff;
               end
            end
            pos_in = pos_next;
            n_in   = n_ff + CW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= hst_pkg::BK_IDLE;
         size_ff   <= hst_pkg::SIZE_RESET;
         valid_ff  <= '0;
         cnt_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (csr_valid && csr_ready) size_ff <= csr_table_size;
         if (wr_en) begin
            valid_ff[pos_ff] <= 1'b1;
            cnt_ff <= cnt_ff + CW'(1);
         end
         if (ovalid_ff && !rsp_stall) ovalid_ff <= 1'b0;
         if (st_ff == hst_pkg::BK_DONE && (!ovalid_ff || !rsp_stall)) ovalid_ff <= 1'b1;
      end
      if (job_take) job_ff <= job_data;
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      pos_ff <= pos_in;
      n_ff   <= n_in;
      if (st_ff == hst_pkg::BK_MOD) home_ff <= pos_in;
      if (st_ff == hst_pkg::BK_READ) begin
         rvalid_ff <= valid_ff[pos_ff];
         rkey_ff   <= key_mem[pos_ff];
         rlen_ff   <= klen_mem[pos_ff];
         rcode_ff  <= code_mem[pos_ff];
      end
      if (wr_en) begin
         key_mem[pos_ff]  <= job_ff.key;
         klen_mem[pos_ff] <= job_ff.key_len;
         code_mem[pos_ff] <= job_ff.code;
      end
      // pending result, moved to the output word only once the last one has gone
      if (st_ff == hst_pkg::BK_MOD && job_ff.too_long) begin
         pst_ff   <= hst_pkg::ST_TOOLONG;
         pslot_ff <= '0;
         pcode_ff <= '0;
      end
      if (res_en) begin
         pst_ff   <= res_st;
         pslot_ff <= 8'(res_slot);
         pcode_ff <= res_code;
      end
      if (st_ff == hst_pkg::BK_DONE && (!ovalid_ff || !rsp_stall)) begin
         ost_ff   <= pst_ff;
         oslot_ff <= pslot_ff;
         ocode_ff <= pcode_ff;
      end
   end

   assign rsp_valid      = ovalid_ff;
   assign rsp_status     = ost_ff;
   assign rsp_slot_index = oslot_ff;
   assign rsp_found_code = ocode_ff;
endmodule
`default_nettype wire

FILE: hdl/hashed_symbol_table.sv
// Top level: hashed symbol table with open addressing and linear probing
// Path: queue, bit-serial modulo, read and check per probe (no probe if too long), result register.
// Throughput: key bytes one per cycle while req_stall is low; one key in back end at a time,
// set by the 32-step bit-serial modulo and the single-port slot read.
// Reset: synchronous; clears valid bits, entry count, key state; size 251.
`default_nettype none
module hashed_symbol_table #(
   parameter int TABLE_DEPTH = hst_pkg::TABLE_DEPTH,
   parameter int MAX_KEY_LEN = hst_pkg::MAX_KEY_LEN
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_req_type,
   input  wire logic [7:0] req_key_byte,
   input  wire logic [7:0] req_token_code,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_status,
   output logic [7:0]      rsp_slot_index,
   output logic [7:0]      rsp_found_code,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [8:0] csr_table_size
);
   logic             f_valid, f_full, b_valid, b_take;
   hst_pkg::job_type f_data, b_data;

   hst_front #(.MAX_KEY_LEN(MAX_KEY_LEN)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_req_type, .req_key_byte,
      .req_token_code, .job_valid(f_valid), .job_full(f_full), .job_data(f_data));

   hst_queue u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_full(f_full), .wr_data(f_data),
      .rd_valid(b_valid), .rd_take(b_take), .rd_data(b_data));

   hst_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock, .reset, .csr_valid, .csr_ready, .csr_table_size,
      .job_valid(b_valid), .job_take(b_take), .job_data(b_data),
      .rsp_valid, .rsp_stall, .rsp_status, .rsp_slot_index, .rsp_found_code);
endmodule
`default_nettype wire
